// ===== design/cda_pkg.sv =====
// Shared types, constants and a helper function for the calendar date adder.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int AMOUNT_W = 16;
  localparam int LEFT_W   = AMOUNT_W + 1;   // month count (month - 1 + amount) can exceed the amount by up to 11
  localparam int SUM_W    = LEFT_W + 1;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = '1;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_FEB_LEAP = 5'd29;

  // floor(x / 25) = (x * DIV25_MAGIC) >> DIV25_SHIFT for any 16-bit x
  localparam logic [16:0] DIV25_MAGIC = 17'd83887;
  localparam int          DIV25_SHIFT = 21;
  // floor(x / 3) = (x * DIV3_MAGIC) >> DIV3_SHIFT for any 15-bit x
  localparam logic [15:0] DIV3_MAGIC  = 16'd43691;
  localparam int          DIV3_SHIFT  = 17;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_DAYS   = 2'd1,
    MODE_MONTHS = 2'd2,
    MODE_YEARS  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MDIV,
    ST_MFIN,
    ST_DAYS,
    ST_YINC,
    ST_LW1,
    ST_LW2,
    ST_DONE
  } state_t;

  // operand pairs of the shared adder
  typedef enum logic [2:0] {
    ADD_DAY,        // day + remaining days
    ADD_AMT,        // 0 + amount
    ADD_MONTH_AMT,  // (month - 1) + amount
    ADD_YEAR_AMT,   // year + amount
    ADD_YEAR_Q,     // year + month carry
    ADD_YEAR_ONE    // year + 1
  } add_sel_t;

  typedef struct packed {
    logic     in_stall;
    add_sel_t add_sel;
    logic     ld_date;
    logic     ld_year;
    logic     ld_left;
    logic     ld_prod;
    logic     ld_month_fin;
    logic     day_step;
    logic     clr_sat;
    logic     out_load;
  } ctl_t;

  typedef struct packed {
    logic fits;       // current day step ends inside this month
    logic dec;        // current month is December
    logic out_free;   // output register can take a new result
  } sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    logic [DAY_W-1:0]   len;
    idx = (month >= 4'd1 && month <= MONTH_DEC) ? month - 4'd1 : 4'd0;
    len = MONTH_LEN[idx];
    if (month == MONTH_FEB && leap) begin
      len = DAY_FEB_LEAP;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/calendar_date_adder.sv =====
// Top level of the calendar date adder: date registers, shared adder, output register.
// Depends on cda_pkg, cda_leap and cda_fsm.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one Gregorian date and applies one command per input transfer: load a
// date, add days, add months or add years; each command returns the date after
// it, with year_saturated set when the year clamped at 65535. One command is
// in flight at a time and the input stalls until its result is in the output
// register. The multiply by a reciprocal for the carry into the year is
// registered. A day add walks one month per cycle on a single shared adder,
// except at each new year, where it waits while the two-stage leap detector
// settles. A finished result waits in the output register, and the next
// command can be taken while it does.
module calendar_date_adder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [cda_pkg::YEAR_W-1:0]    in_new_year,
  input  wire logic [cda_pkg::MONTH_W-1:0]   in_new_month,
  input  wire logic [cda_pkg::DAY_W-1:0]     in_new_day,
  input  wire logic [cda_pkg::AMOUNT_W-1:0]  in_amount,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cda_pkg::YEAR_W-1:0]         out_year,
  output logic [cda_pkg::MONTH_W-1:0]        out_month,
  output logic [cda_pkg::DAY_W-1:0]          out_day,
  output logic                               out_year_saturated
);

  localparam int LEFT_W = cda_pkg::LEFT_W;
  localparam int SUM_W  = cda_pkg::SUM_W;
  localparam int XQ_W   = LEFT_W - 2;          // month count / 4
  localparam int PROD_W = XQ_W + 16;
  localparam int Q12_W  = PROD_W - cda_pkg::DIV3_SHIFT;

  cda_pkg::ctl_t ctl;
  cda_pkg::sts_t sts;

  logic [cda_pkg::YEAR_W-1:0]  year_r, year_nxt;
  logic [cda_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [cda_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [LEFT_W-1:0]           left_r, left_nxt;
  logic [PROD_W-1:0]           prod_r;
  logic                        sat_r, sat_nxt;
  logic                        leap;

  logic [cda_pkg::YEAR_W-1:0]  oyear_r;
  logic [cda_pkg::MONTH_W-1:0] omonth_r;
  logic [cda_pkg::DAY_W-1:0]   oday_r;
  logic                        osat_r;
  logic                        ovalid_r, ovalid_nxt;

  logic [LEFT_W-1:0]           add_a, add_b;
  logic [SUM_W-1:0]            sum;
  logic [cda_pkg::DAY_W-1:0]   len;
  logic [Q12_W-1:0]            q12;
  logic [LEFT_W-1:0]           q12_x12;
  logic [LEFT_W-1:0]           mrem;
  logic                        year_ovf;

  cda_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .sts      (sts),
    .ctl      (ctl)
  );

  cda_leap u_leap (
    .clk   (clk),
    .rst_n (rst_n),
    .year  (year_r),
    .leap  (leap)
  );

  // shared adder operand select
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (ctl.add_sel)
      cda_pkg::ADD_DAY: begin
        add_a = LEFT_W'(day_r);
        add_b = left_r;
      end
      cda_pkg::ADD_AMT: add_b = LEFT_W'(in_amount);
      cda_pkg::ADD_MONTH_AMT: begin
        add_a = LEFT_W'(month_r - 4'd1);
        add_b = LEFT_W'(in_amount);
      end
      cda_pkg::ADD_YEAR_AMT: begin
        add_a = LEFT_W'(year_r);
        add_b = LEFT_W'(in_amount);
      end
      cda_pkg::ADD_YEAR_Q: begin
        add_a = LEFT_W'(year_r);
        add_b = LEFT_W'(q12);
      end
      cda_pkg::ADD_YEAR_ONE: begin
        add_a = LEFT_W'(year_r);
        add_b = LEFT_W'(1);
      end
      default: ;
    endcase
  end

  assign sum      = SUM_W'(add_a) + SUM_W'(add_b);
  assign year_ovf = (sum[SUM_W-1:cda_pkg::YEAR_W] != '0);
  assign len      = cda_pkg::month_days(month_r, leap);

  // month count split into years and months: q = t / 12, remainder t - 12q
  assign q12     = prod_r[cda_pkg::DIV3_SHIFT +: Q12_W];
  assign q12_x12 = (LEFT_W'(q12) << 3) + (LEFT_W'(q12) << 2);
  assign mrem    = left_r - q12_x12;

  assign sts.fits     = (sum <= SUM_W'(len));
  assign sts.dec      = (month_r == cda_pkg::MONTH_DEC);
  assign sts.out_free = !ovalid_r || !out_stall;

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    left_nxt  = left_r;
    sat_nxt   = sat_r;
    if (ctl.clr_sat) begin
      sat_nxt = 1'b0;
    end
    if (ctl.ld_date) begin
      year_nxt = in_new_year;
      if (in_new_month == 4'd0) begin
        month_nxt = 4'd1;
      end else if (in_new_month > cda_pkg::MONTH_DEC) begin
        month_nxt = cda_pkg::MONTH_DEC;
      end else begin
        month_nxt = in_new_month;
      end
      day_nxt = (in_new_day == '0) ? 5'd1 : in_new_day;
    end
    if (ctl.ld_year) begin
      if (year_ovf) begin
        year_nxt = cda_pkg::YEAR_MAX;
        sat_nxt  = 1'b1;
      end else begin
        year_nxt = sum[cda_pkg::YEAR_W-1:0];
      end
    end
    if (ctl.ld_left) begin
      left_nxt = sum[LEFT_W-1:0];
    end
    if (ctl.ld_month_fin) begin
      month_nxt = mrem[cda_pkg::MONTH_W-1:0] + 4'd1;
    end
    if (ctl.day_step) begin
      if (sts.fits) begin
        day_nxt = sum[cda_pkg::DAY_W-1:0];
      end else begin
        // spill into the next month
        day_nxt   = 5'd1;
        left_nxt  = LEFT_W'(sum - SUM_W'(len) - SUM_W'(1));
        month_nxt = sts.dec ? 4'd1 : month_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= '0;
      month_r <= 4'd1;
      day_r   <= 5'd1;
      sat_r   <= 1'b0;
    end else begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    if (ctl.ld_prod) begin
      prod_r <= PROD_W'(left_r[LEFT_W-1:2]) * PROD_W'(cda_pkg::DIV3_MAGIC);
    end
  end

  // output register
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (ctl.out_load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      oyear_r  <= year_r;
      omonth_r <= month_r;
      oday_r   <= day_r;
      osat_r   <= sat_r;
    end
  end

  assign in_stall           = ctl.in_stall;
  assign out_valid          = ovalid_r;
  assign out_year           = oyear_r;
  assign out_month          = omonth_r;
  assign out_day            = oday_r;
  assign out_year_saturated = osat_r;

`ifndef SYNTHESIS
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (month_r >= 4'd1) && (month_r <= cda_pkg::MONTH_DEC))
    else $error("current month out of range");

  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    day_r != '0)
    else $error("current day is zero");

  a_sat_means_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_saturated) |-> out_year == cda_pkg::YEAR_MAX)
    else $error("saturation flagged below the maximum year");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!ovalid_r || !out_stall))
    else $error("result loaded over a pending result");
`endif

endmodule

`default_nettype wire

// ===== design/cda_leap.sv =====
// Two-stage Gregorian leap-year detector for the current year.
// Depends on cda_pkg (widths and the divide-by-25 reciprocal).
`timescale 1ns / 1ps
`default_nettype none

module cda_leap (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [cda_pkg::YEAR_W-1:0] year,
  output logic                            leap
);

  localparam int PROD_W = cda_pkg::YEAR_W + 17;
  localparam int Q_W    = 12;

  logic [PROD_W-1:0]           prod;
  logic [Q_W-1:0]              q_r;
  logic [cda_pkg::YEAR_W-1:0]  y_r;
  logic                        leap_r;
  logic [cda_pkg::YEAR_W-1:0]  q_x25;
  logic                        div25;
  logic                        leap_nxt;

  assign prod = PROD_W'(year) * PROD_W'(cda_pkg::DIV25_MAGIC);

  // 25 * q from shifts: 16q + 8q + q
  assign q_x25 = (cda_pkg::YEAR_W'(q_r) << 4) + (cda_pkg::YEAR_W'(q_r) << 3)
               + cda_pkg::YEAR_W'(q_r);
  assign div25 = (y_r == q_x25);
  // divisible by 4, and either not by 100 or also by 400
  assign leap_nxt = (y_r[1:0] == 2'd0) && (!div25 || (y_r[3:0] == 4'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= '0;
      y_r    <= '0;
      leap_r <= 1'b1;   // year 0 is a leap year
    end else begin
      q_r    <= prod[cda_pkg::DIV25_SHIFT +: Q_W];
      y_r    <= year;
      leap_r <= leap_nxt;
    end
  end

  assign leap = leap_r;

endmodule

`default_nettype wire

// ===== design/cda_fsm.sv =====
// Sequencer for the calendar date adder: steps the shared adder through each command.
// Depends on cda_pkg (state, mode, control and status types).
`timescale 1ns / 1ps
`default_nettype none

module cda_fsm (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [1:0]   in_mode,
  input  wire cda_pkg::sts_t sts,
  output cda_pkg::ctl_t     ctl
);

  cda_pkg::state_t state_r, state_nxt;
  cda_pkg::mode_t  mode_r, mode_nxt;
  cda_pkg::mode_t  in_mode_e;

  assign in_mode_e = cda_pkg::mode_t'(in_mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cda_pkg::ST_IDLE;
      mode_r  <= cda_pkg::MODE_LOAD;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      cda_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode_e;
          unique case (in_mode_e)
            cda_pkg::MODE_DAYS:   state_nxt = cda_pkg::ST_DAYS;
            cda_pkg::MODE_MONTHS: state_nxt = cda_pkg::ST_MDIV;
            default:              state_nxt = cda_pkg::ST_LW1;
          endcase
        end
      end
      cda_pkg::ST_MDIV: state_nxt = cda_pkg::ST_MFIN;
      cda_pkg::ST_MFIN: state_nxt = cda_pkg::ST_LW1;
      cda_pkg::ST_DAYS: begin
        if (sts.fits) begin
          state_nxt = cda_pkg::ST_DONE;
        end else if (sts.dec) begin
          state_nxt = cda_pkg::ST_YINC;
        end
      end
      cda_pkg::ST_YINC: state_nxt = cda_pkg::ST_LW1;
      cda_pkg::ST_LW1:  state_nxt = cda_pkg::ST_LW2;
      // leap flag settles here; resume the day walk or finish
      cda_pkg::ST_LW2: begin
        state_nxt = (mode_r == cda_pkg::MODE_DAYS) ? cda_pkg::ST_DAYS : cda_pkg::ST_DONE;
      end
      cda_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = cda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cda_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl          = '0;
    ctl.add_sel  = cda_pkg::ADD_DAY;
    ctl.in_stall = (state_r != cda_pkg::ST_IDLE);
    unique case (state_r)
      cda_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.clr_sat = 1'b1;
          unique case (in_mode_e)
            cda_pkg::MODE_LOAD: ctl.ld_date = 1'b1;
            cda_pkg::MODE_DAYS: begin
              ctl.add_sel = cda_pkg::ADD_AMT;
              ctl.ld_left = 1'b1;
            end
            cda_pkg::MODE_MONTHS: begin
              ctl.add_sel = cda_pkg::ADD_MONTH_AMT;
              ctl.ld_left = 1'b1;
            end
            default: begin
              ctl.add_sel = cda_pkg::ADD_YEAR_AMT;
              ctl.ld_year = 1'b1;
            end
          endcase
        end
      end
      cda_pkg::ST_MDIV: ctl.ld_prod = 1'b1;
      cda_pkg::ST_MFIN: begin
        ctl.add_sel      = cda_pkg::ADD_YEAR_Q;
        ctl.ld_year      = 1'b1;
        ctl.ld_month_fin = 1'b1;
      end
      cda_pkg::ST_DAYS: begin
        ctl.add_sel  = cda_pkg::ADD_DAY;
        ctl.day_step = 1'b1;
      end
      cda_pkg::ST_YINC: begin
        ctl.add_sel = cda_pkg::ADD_YEAR_ONE;
        ctl.ld_year = 1'b1;
      end
      cda_pkg::ST_DONE: ctl.out_load = sts.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cda_pkg::ST_IDLE && in_valid) |=> ctl.in_stall)
    else $error("block did not go busy after an input transfer");

  a_days_only_in_day_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cda_pkg::ST_DAYS || state_r == cda_pkg::ST_YINC)
      |-> mode_r == cda_pkg::MODE_DAYS)
    else $error("day walk running for a non-day command");

  a_done_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cda_pkg::ST_LW2 && mode_r != cda_pkg::MODE_DAYS)
      |=> state_r == cda_pkg::ST_DONE)
    else $error("command did not finish after leap settle");
`endif

endmodule

`default_nettype wire
